@@ src/ctok_pkg.sv @@
// Package for the source tokenizer: item and result types, token kinds,
// error codes, keyword table and character class functions.
// No dependencies.
package ctok_pkg;

	// Input item: one source byte and a restart flag.
	typedef struct packed {
		logic [7:0] text_byte;
		logic       new_text;
	} in_item_t;

	// Result item: one byte of token text or a token completion.
	typedef struct packed {
		logic [3:0]  token_kind;
		logic [7:0]  token_char;
		logic        has_char;
		logic        token_done;
		logic [1:0]  error_code;
		logic [23:0] line_number;
		logic        last;
	} result_t;

	// Results produced by one scan step, handed to the result queue.
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

	// Scanner modes.
	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_IDENT   = 3'd1,
		MODE_NUMBER  = 3'd2,
		MODE_STRING  = 3'd3,
		MODE_LINECOM = 3'd4,
		MODE_BLOCK   = 3'd5,
		MODE_BSTAR   = 3'd6,
		MODE_HOLD    = 3'd7
	} mode_t;

	// Token kinds.
	localparam logic [3:0] KIND_END    = 4'd0;
	localparam logic [3:0] KIND_IDENT  = 4'd8;
	localparam logic [3:0] KIND_STRING = 4'd9;
	localparam logic [3:0] KIND_NUMBER = 4'd10;
	localparam logic [3:0] KIND_INC    = 4'd11;
	localparam logic [3:0] KIND_EQ     = 4'd12;
	localparam logic [3:0] KIND_AND    = 4'd13;
	localparam logic [3:0] KIND_SINGLE = 4'd14;

	// Error codes.
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_STRING = 2'd1;
	localparam logic [1:0] ERR_BLOCK  = 2'd2;

	// Characters with a special meaning.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQ    = 8'h3D;

	// Result queue depth.
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_BITS = 2;

	// Keyword table: int, float, if, for, break, function, include.
	localparam int KW_COUNT = 7;
	localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
		'{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00},
		'{"f", "u", "n", "c", "t", "i", "o", "n"},
		'{"i", "n", "c", "l", "u", "d", "e", 8'h00}
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd5, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7
	};

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// Whitespace outside strings: control bytes, space and the high half.
	function automatic logic is_space(input logic [7:0] c);
		return c <= CH_SPACE || c[7];
	endfunction

	function automatic logic is_op_start(input logic [7:0] c);
		return c == CH_PLUS || c == CH_EQ || c == CH_AMP || c == CH_SLASH;
	endfunction

	// Drop keywords that do not match character c at position wl.
	function automatic logic [KW_COUNT-1:0] absorb_hits(
		input logic [KW_COUNT-1:0] hits,
		input logic [3:0]          wl,
		input logic [7:0]          c
	);
		logic [KW_COUNT-1:0] res;
		res = hits;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (!(wl < KW_LEN[k] && KW_TEXT[k][wl[2:0]] == c)) begin
				res[k] = 1'b0;
			end
		end
		return res;
	endfunction

	// Final kind of an identifier: the first keyword still matching in full.
	function automatic logic [3:0] ident_kind(
		input logic [KW_COUNT-1:0] hits,
		input logic [3:0]          wl
	);
		logic [3:0] kind;
		kind = KIND_IDENT;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (hits[k] && wl == KW_LEN[k]) begin
				kind = 4'(k + 1);
			end
		end
		return kind;
	endfunction

	function automatic result_t mk_result(
		input logic [3:0]  kind,
		input logic [7:0]  ch,
		input logic        has,
		input logic        done,
		input logic [1:0]  err,
		input logic [23:0] line
	);
		result_t r;
		r.token_kind  = kind;
		r.token_char  = has ? ch : 8'h00;
		r.has_char    = has;
		r.token_done  = done;
		r.error_code  = err;
		r.line_number = line;
		r.last        = 1'b0;
		return r;
	endfunction

endpackage

@@ src/ctok_lexer.sv @@
// Scan state and the combinational scan step of the tokenizer.
// Depends on ctok_pkg.
module ctok_lexer #(
	parameter int LINE_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  ctok_pkg::in_item_t  item,
	output ctok_pkg::push_t     push
);

	ctok_pkg::mode_t                    mode_q, cur_mode, nxt_mode;
	logic [7:0]                         held_q, cur_held, nxt_held;
	logic [ctok_pkg::KW_COUNT-1:0]      hits_q, cur_hits, nxt_hits;
	logic [3:0]                         wl_q, cur_wl, nxt_wl;
	logic [LINE_BITS-1:0]               line_q, cur_line, nxt_line;
	logic [LINE_BITS+23:0]              line_ext;
	logic [23:0]                        line_out;
	logic [7:0]                         c;
	logic [1:0]                         n;
	ctok_pkg::result_t                  r0, r1, rx;
	logic                               have_rx;
	logic                               go_begin;
	logic                               inc_line;

	// A restart applies before the byte is scanned.
	always_comb begin
		if (item.new_text) begin
			cur_mode = ctok_pkg::MODE_IDLE;
			cur_held = 8'h00;
			cur_hits = '1;
			cur_wl   = 4'd0;
			cur_line = LINE_BITS'(1);
		end else begin
			cur_mode = mode_q;
			cur_held = held_q;
			cur_hits = hits_q;
			cur_wl   = wl_q;
			cur_line = line_q;
		end
	end

	assign c        = item.text_byte;
	assign line_ext = {24'd0, cur_line};
	assign line_out = line_ext[23:0];

	// Mode-specific handling; an item may hand over to the idle handling.
	always_comb begin
		nxt_mode = cur_mode;
		nxt_held = cur_held;
		nxt_hits = cur_hits;
		nxt_wl   = cur_wl;
		go_begin = 1'b0;
		inc_line = 1'b0;
		have_rx  = 1'b0;
		rx       = '0;
		r0       = '0;
		r1       = '0;
		n        = 2'd0;

		case (cur_mode)
			ctok_pkg::MODE_IDENT: begin
				if (ctok_pkg::is_alpha(c) || ctok_pkg::is_digit(c)) begin
					nxt_hits = ctok_pkg::absorb_hits(cur_hits, cur_wl, c);
					nxt_wl   = (cur_wl < 4'd15) ? cur_wl + 4'd1 : cur_wl;
					r0 = ctok_pkg::mk_result(ctok_pkg::KIND_IDENT, c, 1'b1, 1'b0,
						ctok_pkg::ERR_NONE, line_out);
					n = 2'd1;
				end else begin
					r0 = ctok_pkg::mk_result(ctok_pkg::ident_kind(cur_hits, cur_wl), 8'h00,
						1'b0, 1'b1, ctok_pkg::ERR_NONE, line_out);
					n = 2'd1;
					go_begin = 1'b1;
				end
			end
			ctok_pkg::MODE_NUMBER: begin
				if (ctok_pkg::is_digit(c) || c == ctok_pkg::CH_DOT) begin
					r0 = ctok_pkg::mk_result(ctok_pkg::KIND_NUMBER, c, 1'b1, 1'b0,
						ctok_pkg::ERR_NONE, line_out);
					n = 2'd1;
				end else begin
					r0 = ctok_pkg::mk_result(ctok_pkg::KIND_NUMBER, 8'h00, 1'b0, 1'b1,
						ctok_pkg::ERR_NONE, line_out);
					n = 2'd1;
					go_begin = 1'b1;
				end
			end
			ctok_pkg::MODE_STRING: begin
				if (c == ctok_pkg::CH_QUOTE) begin
					r0 = ctok_pkg::mk_result(ctok_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1,
						ctok_pkg::ERR_NONE, line_out);
					n = 2'd1;
					nxt_mode = ctok_pkg::MODE_IDLE;
				end else if (c == ctok_pkg::CH_NUL || c == ctok_pkg::CH_CR ||
						c == ctok_pkg::CH_LF) begin
					r0 = ctok_pkg::mk_result(ctok_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1,
						ctok_pkg::ERR_STRING, line_out);
					n = 2'd1;
					go_begin = 1'b1;
				end else begin
					r0 = ctok_pkg::mk_result(ctok_pkg::KIND_STRING, c, 1'b1, 1'b0,
						ctok_pkg::ERR_NONE, line_out);
					n = 2'd1;
				end
			end
			ctok_pkg::MODE_LINECOM: begin
				if (c == ctok_pkg::CH_NUL || c == ctok_pkg::CH_CR ||
						c == ctok_pkg::CH_LF) begin
					go_begin = 1'b1;
				end
			end
			ctok_pkg::MODE_BLOCK, ctok_pkg::MODE_BSTAR: begin
				if (c == ctok_pkg::CH_NUL) begin
					r0 = ctok_pkg::mk_result(ctok_pkg::KIND_END, 8'h00, 1'b0, 1'b1,
						ctok_pkg::ERR_BLOCK, line_out);
					n = 2'd1;
					nxt_mode = ctok_pkg::MODE_IDLE;
				end else if (c == ctok_pkg::CH_STAR) begin
					nxt_mode = ctok_pkg::MODE_BSTAR;
				end else if (c == ctok_pkg::CH_SLASH && cur_mode == ctok_pkg::MODE_BSTAR) begin
					nxt_mode = ctok_pkg::MODE_IDLE;
				end else begin
					inc_line = (c == ctok_pkg::CH_LF);
					nxt_mode = ctok_pkg::MODE_BLOCK;
				end
			end
			ctok_pkg::MODE_HOLD: begin
				nxt_held = 8'h00;
				if (cur_held == ctok_pkg::CH_SLASH && c == ctok_pkg::CH_STAR) begin
					nxt_mode = ctok_pkg::MODE_BLOCK;
				end else if (cur_held == ctok_pkg::CH_SLASH && c == ctok_pkg::CH_SLASH) begin
					nxt_mode = ctok_pkg::MODE_LINECOM;
				end else if (c == cur_held && cur_held != ctok_pkg::CH_SLASH) begin
					// Two-byte operator: both bytes go out, the second completes it.
					r0 = ctok_pkg::mk_result(
						(cur_held == ctok_pkg::CH_PLUS) ? ctok_pkg::KIND_INC :
						(cur_held == ctok_pkg::CH_EQ) ? ctok_pkg::KIND_EQ : ctok_pkg::KIND_AND,
						cur_held, 1'b1, 1'b0, ctok_pkg::ERR_NONE, line_out);
					r1 = r0;
					r1.token_done = 1'b1;
					n = 2'd2;
					nxt_mode = ctok_pkg::MODE_IDLE;
				end else begin
					r0 = ctok_pkg::mk_result(ctok_pkg::KIND_SINGLE, cur_held, 1'b1, 1'b1,
						ctok_pkg::ERR_NONE, line_out);
					n = 2'd1;
					go_begin = 1'b1;
				end
			end
			default: begin
				go_begin = 1'b1;
			end
		endcase

		// Idle handling: start of a new token, whitespace or end of text.
		if (go_begin) begin
			nxt_mode = ctok_pkg::MODE_IDLE;
			if (c == ctok_pkg::CH_NUL) begin
				rx = ctok_pkg::mk_result(ctok_pkg::KIND_END, 8'h00, 1'b0, 1'b1,
					ctok_pkg::ERR_NONE, line_out);
				have_rx = 1'b1;
			end else if (ctok_pkg::is_space(c)) begin
				inc_line = (c == ctok_pkg::CH_LF);
			end else if (c == ctok_pkg::CH_QUOTE) begin
				nxt_mode = ctok_pkg::MODE_STRING;
			end else if (ctok_pkg::is_alpha(c)) begin
				nxt_mode = ctok_pkg::MODE_IDENT;
				nxt_hits = ctok_pkg::absorb_hits('1, 4'd0, c);
				nxt_wl   = 4'd1;
				rx = ctok_pkg::mk_result(ctok_pkg::KIND_IDENT, c, 1'b1, 1'b0,
					ctok_pkg::ERR_NONE, line_out);
				have_rx = 1'b1;
			end else if (ctok_pkg::is_digit(c)) begin
				nxt_mode = ctok_pkg::MODE_NUMBER;
				rx = ctok_pkg::mk_result(ctok_pkg::KIND_NUMBER, c, 1'b1, 1'b0,
					ctok_pkg::ERR_NONE, line_out);
				have_rx = 1'b1;
			end else if (ctok_pkg::is_op_start(c)) begin
				nxt_mode = ctok_pkg::MODE_HOLD;
				nxt_held = c;
			end else begin
				rx = ctok_pkg::mk_result(ctok_pkg::KIND_SINGLE, c, 1'b1, 1'b1,
					ctok_pkg::ERR_NONE, line_out);
				have_rx = 1'b1;
			end
		end

		// Place the idle handling's result after any earlier one.
		if (have_rx) begin
			if (n == 2'd0) begin
				r0 = rx;
			end else begin
				r1 = rx;
			end
			n = n + 2'd1;
		end

		// Mark the last result of this item.
		if (n == 2'd2) begin
			r1.last = 1'b1;
		end else begin
			r0.last = 1'b1;
		end
	end

	// Saturating line counter.
	assign nxt_line = (inc_line && cur_line != '1) ? cur_line + LINE_BITS'(1) : cur_line;

	assign push.count = step ? n : 2'd0;
	assign push.r0    = r0;
	assign push.r1    = r1;

	// Scan state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ctok_pkg::MODE_IDLE;
			held_q <= 8'h00;
			hits_q <= '1;
			wl_q   <= 4'd0;
			line_q <= LINE_BITS'(1);
		end else if (step) begin
			mode_q <= nxt_mode;
			held_q <= nxt_held;
			hits_q <= nxt_hits;
			wl_q   <= nxt_wl;
			line_q <= nxt_line;
		end
	end

endmodule

@@ src/ctok_rqueue.sv @@
// Result queue of the tokenizer: takes up to two results per cycle and
// hands out one per handshake. Depends on ctok_pkg.
module ctok_rqueue (
	input  logic               clk,
	input  logic               arst_n,
	input  ctok_pkg::push_t    push,
	output logic               room,
	output logic               tok_valid,
	input  logic               tok_ready,
	output ctok_pkg::result_t  tok_item
);

	localparam int CNT_BITS = ctok_pkg::RQ_PTR_BITS + 1;

	ctok_pkg::result_t                entry_q [ctok_pkg::RQ_DEPTH];
	logic [ctok_pkg::RQ_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
	logic [CNT_BITS-1:0]              count_q;
	logic                             pop;

	// Room for the two results a scan step may produce.
	assign room      = count_q <= CNT_BITS'(ctok_pkg::RQ_DEPTH - 2);
	assign tok_valid = count_q != '0;
	assign tok_item  = entry_q[rd_ptr_q];
	assign pop       = tok_valid && tok_ready;
	assign wr_ptr_nx = wr_ptr_q + ctok_pkg::RQ_PTR_BITS'(1);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_ptr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_ptr_nx] <= push.r1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + ctok_pkg::RQ_PTR_BITS'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ctok_pkg::RQ_PTR_BITS'(1);
			end
			count_q <= count_q + CNT_BITS'(push.count) - CNT_BITS'(pop);
		end
	end

endmodule

@@ src/c_like_source_tokenizer.sv @@
// Streaming tokenizer: one source byte per item in, token text and
// completions out. An accepted item is held in the input register and
// scanned once the result queue has room; its results are offered from
// the result queue. One item per cycle is taken while the queue has room;
// the output gives one result per cycle while the receiver is ready, and a
// four-entry result queue absorbs the burst of an item with two results.
// Reset clears the scan mode, keyword state and queue and sets the line to 1.
module c_like_source_tokenizer #(
	parameter int LINE_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_ready,
	input  ctok_pkg::in_item_t src_item,
	output logic               tok_valid,
	input  logic               tok_ready,
	output ctok_pkg::result_t  tok_item
);

	ctok_pkg::in_item_t item_s1;
	logic               valid_s1;
	logic               room;
	logic               step;
	ctok_pkg::push_t    push;

	// The registered item is scanned once the queue can take its results.
	assign step      = valid_s1 && room;
	assign src_ready = !valid_s1 || step;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready) begin
			item_s1 <= src_item;
		end
	end

	ctok_lexer #(
		.LINE_BITS(LINE_BITS)
	) u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.push   (push)
	);

	ctok_rqueue u_rqueue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_item  (tok_item)
	);

endmodule

@@ dv/tb.sv @@
// Testbench for c_like_source_tokenizer: streams source bytes, predicts the token items in
// a scoreboard model and checks every result item in order under random idling.
// Depends on ctok_pkg and the tokenizer RTL.
`timescale 1ns / 100ps

module tb;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               src_valid = 1'b0;
	logic               src_ready;
	ctok_pkg::in_item_t src_item = '0;
	logic               tok_valid;
	logic               tok_ready = 1'b0;
	ctok_pkg::result_t  tok_item;

	// Idling percentages for the sender and the receiver.
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int errors = 0;
	int bytes_sent = 0;

	// Tokens predicted from the accepted bytes, oldest first.
	ctok_pkg::result_t expected_tokens[$];

	// Lexer state of the prediction.
	ctok_pkg::mode_t lex_mode = ctok_pkg::MODE_IDLE;
	logic [7:0]      lex_held = 8'h00;
	logic [6:0]      lex_hits = 7'h7F;
	logic [3:0]      lex_wlen = 4'd0;
	logic [23:0]     lex_line = 24'd1;
	int              step_results = 0;

	c_like_source_tokenizer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_item (src_item),
		.tok_valid(tok_valid),
		.tok_ready(tok_ready),
		.tok_item (tok_item)
	);

	always #10 clk = ~clk;

	// Receiver stalls are decided once per cycle.
	always @(negedge clk) begin
		tok_ready = ($urandom_range(99) >= sink_stall_pct);
	end

	function automatic string keyword_of(input int k);
		case (k)
			0: return "int";
			1: return "float";
			2: return "if";
			3: return "for";
			4: return "break";
			5: return "function";
			default: return "include";
		endcase
	endfunction

	function automatic logic letter_char(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic numeral_char(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// Append one predicted token item; a byte causes two at most.
	function automatic void queue_token(input logic [3:0] kind, input logic [7:0] ch,
			input logic has, input logic done, input logic [1:0] err);
		ctok_pkg::result_t r;
		if (step_results >= 2) begin
			return;
		end
		r.token_kind  = kind;
		r.token_char  = has ? ch : 8'h00;
		r.has_char    = has;
		r.token_done  = done;
		r.error_code  = err;
		r.line_number = lex_line;
		r.last        = 1'b0;
		expected_tokens.push_back(r);
		step_results++;
	endfunction

	function automatic void count_line();
		if (lex_line != 24'hFFFFFF) begin
			lex_line++;
		end
	endfunction

	// Add one identifier byte and drop the keywords it no longer matches.
	function automatic void absorb_word(input logic [7:0] c);
		string kw;
		for (int k = 0; k < 7; k++) begin
			kw = keyword_of(k);
			if (!(lex_wlen < kw.len() && kw[lex_wlen] == c)) begin
				lex_hits[k] = 1'b0;
			end
		end
		if (lex_wlen < 4'd15) begin
			lex_wlen++;
		end
		queue_token(ctok_pkg::KIND_IDENT, c, 1'b1, 1'b0, ctok_pkg::ERR_NONE);
	endfunction

	function automatic logic [3:0] word_kind();
		string kw;
		for (int k = 0; k < 7; k++) begin
			kw = keyword_of(k);
			if (lex_hits[k] && lex_wlen == kw.len()) begin
				return 4'(k + 1);
			end
		end
		return ctok_pkg::KIND_IDENT;
	endfunction

	// Handle a byte from the state between tokens.
	function automatic void start_token(input logic [7:0] c);
		lex_mode = ctok_pkg::MODE_IDLE;
		if (c == ctok_pkg::CH_NUL) begin
			queue_token(ctok_pkg::KIND_END, 8'h00, 1'b0, 1'b1, ctok_pkg::ERR_NONE);
		end else if (c <= ctok_pkg::CH_SPACE || c >= 8'h80) begin
			if (c == ctok_pkg::CH_LF) begin
				count_line();
			end
		end else if (c == ctok_pkg::CH_QUOTE) begin
			lex_mode = ctok_pkg::MODE_STRING;
		end else if (letter_char(c)) begin
			lex_mode = ctok_pkg::MODE_IDENT;
			lex_wlen = 4'd0;
			lex_hits = 7'h7F;
			absorb_word(c);
		end else if (numeral_char(c)) begin
			lex_mode = ctok_pkg::MODE_NUMBER;
			queue_token(ctok_pkg::KIND_NUMBER, c, 1'b1, 1'b0, ctok_pkg::ERR_NONE);
		end else if (c == ctok_pkg::CH_PLUS || c == ctok_pkg::CH_EQ ||
				c == ctok_pkg::CH_AMP || c == ctok_pkg::CH_SLASH) begin
			lex_mode = ctok_pkg::MODE_HOLD;
			lex_held = c;
		end else begin
			queue_token(ctok_pkg::KIND_SINGLE, c, 1'b1, 1'b1, ctok_pkg::ERR_NONE);
		end
	endfunction

	// Predict the token items that one accepted byte causes.
	function automatic void lex_byte(input logic [7:0] c, input logic restart);
		logic [7:0]        h;
		logic [3:0]        kind;
		ctok_pkg::result_t r;
		step_results = 0;
		if (restart) begin
			lex_mode = ctok_pkg::MODE_IDLE;
			lex_held = 8'h00;
			lex_hits = 7'h7F;
			lex_wlen = 4'd0;
			lex_line = 24'd1;
		end
		case (lex_mode)
			ctok_pkg::MODE_IDENT: begin
				if (letter_char(c) || numeral_char(c)) begin
					absorb_word(c);
				end else begin
					queue_token(word_kind(), 8'h00, 1'b0, 1'b1, ctok_pkg::ERR_NONE);
					start_token(c);
				end
			end
			ctok_pkg::MODE_NUMBER: begin
				if (numeral_char(c) || c == ctok_pkg::CH_DOT) begin
					queue_token(ctok_pkg::KIND_NUMBER, c, 1'b1, 1'b0, ctok_pkg::ERR_NONE);
				end else begin
					queue_token(ctok_pkg::KIND_NUMBER, 8'h00, 1'b0, 1'b1,
						ctok_pkg::ERR_NONE);
					start_token(c);
				end
			end
			ctok_pkg::MODE_STRING: begin
				if (c == ctok_pkg::CH_QUOTE) begin
					queue_token(ctok_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1,
						ctok_pkg::ERR_NONE);
					lex_mode = ctok_pkg::MODE_IDLE;
				end else if (c == ctok_pkg::CH_NUL || c == ctok_pkg::CH_CR ||
						c == ctok_pkg::CH_LF) begin
					queue_token(ctok_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1,
						ctok_pkg::ERR_STRING);
					start_token(c);
				end else begin
					queue_token(ctok_pkg::KIND_STRING, c, 1'b1, 1'b0, ctok_pkg::ERR_NONE);
				end
			end
			ctok_pkg::MODE_LINECOM: begin
				if (c == ctok_pkg::CH_NUL || c == ctok_pkg::CH_CR ||
						c == ctok_pkg::CH_LF) begin
					start_token(c);
				end
			end
			ctok_pkg::MODE_BLOCK, ctok_pkg::MODE_BSTAR: begin
				if (c == ctok_pkg::CH_NUL) begin
					queue_token(ctok_pkg::KIND_END, 8'h00, 1'b0, 1'b1, ctok_pkg::ERR_BLOCK);
					lex_mode = ctok_pkg::MODE_IDLE;
				end else if (c == ctok_pkg::CH_STAR) begin
					lex_mode = ctok_pkg::MODE_BSTAR;
				end else if (c == ctok_pkg::CH_SLASH && lex_mode == ctok_pkg::MODE_BSTAR) begin
					lex_mode = ctok_pkg::MODE_IDLE;
				end else begin
					if (c == ctok_pkg::CH_LF) begin
						count_line();
					end
					lex_mode = ctok_pkg::MODE_BLOCK;
				end
			end
			ctok_pkg::MODE_HOLD: begin
				h = lex_held;
				lex_held = 8'h00;
				if (h == ctok_pkg::CH_SLASH && c == ctok_pkg::CH_STAR) begin
					lex_mode = ctok_pkg::MODE_BLOCK;
				end else if (h == ctok_pkg::CH_SLASH && c == ctok_pkg::CH_SLASH) begin
					lex_mode = ctok_pkg::MODE_LINECOM;
				end else if (c == h && (h == ctok_pkg::CH_PLUS || h == ctok_pkg::CH_EQ ||
						h == ctok_pkg::CH_AMP)) begin
					kind = (h == ctok_pkg::CH_PLUS) ? ctok_pkg::KIND_INC :
						(h == ctok_pkg::CH_EQ) ? ctok_pkg::KIND_EQ : ctok_pkg::KIND_AND;
					queue_token(kind, h, 1'b1, 1'b0, ctok_pkg::ERR_NONE);
					queue_token(kind, h, 1'b1, 1'b1, ctok_pkg::ERR_NONE);
					lex_mode = ctok_pkg::MODE_IDLE;
				end else begin
					queue_token(ctok_pkg::KIND_SINGLE, h, 1'b1, 1'b1, ctok_pkg::ERR_NONE);
					start_token(c);
				end
			end
			default: begin
				start_token(c);
			end
		endcase
		// The final item of this byte carries the last flag.
		if (step_results > 0) begin
			r = expected_tokens.pop_back();
			r.last = 1'b1;
			expected_tokens.push_back(r);
		end
	endfunction

	// Check each delivered token item, then predict from each accepted byte.
	always @(posedge clk) begin
		ctok_pkg::result_t want;
		if (arst_n) begin
			if (tok_valid === 1'b1 && tok_ready) begin
				if (expected_tokens.size() == 0) begin
					$display("%0t: unexpected token item: kind %0d char %h done %b err %0d",
						$time, tok_item.token_kind, tok_item.token_char,
						tok_item.token_done, tok_item.error_code);
					errors++;
				end else begin
					want = expected_tokens.pop_front();
					if (tok_item !== want) begin
						$display("%0t: token mismatch: expected kind %0d char %h has %b ",
							$time, want.token_kind, want.token_char, want.has_char,
							"done %b err %0d line %0d last %b, ",
							want.token_done, want.error_code, want.line_number, want.last,
							"actual kind %0d char %h has %b ",
							tok_item.token_kind, tok_item.token_char, tok_item.has_char,
							"done %b err %0d line %0d last %b",
							tok_item.token_done, tok_item.error_code,
							tok_item.line_number, tok_item.last);
						errors++;
					end
				end
			end
			if (src_valid && src_ready === 1'b1) begin
				lex_byte(src_item.text_byte, src_item.new_text);
			end
		end
	end

	// Send one byte; called and returning at a falling edge.
	task automatic send_byte(input logic [7:0] b, input logic restart);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < src_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			src_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		src_item.text_byte = b;
		src_item.new_text = restart;
		src_valid = 1'b1;
		do begin
			@(posedge clk);
		end while (src_ready !== 1'b1);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i], 1'b0);
		end
	endtask

	// Hold the sender until every predicted item has come out.
	task automatic wait_drained();
		src_valid = 1'b0;
		while (expected_tokens.size() != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
	endtask

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(52);
		if (r < 26) begin
			return 8'("a" + r);
		end else if (r < 52) begin
			return 8'("A" + r - 26);
		end
		return "_";
	endfunction

	function automatic logic [7:0] rand_numeral();
		return 8'("0" + $urandom_range(9));
	endfunction

	function automatic logic [7:0] rand_word_char();
		return ($urandom_range(4) == 0) ? rand_numeral() : rand_letter();
	endfunction

	function automatic logic [7:0] rand_blank();
		case ($urandom_range(5))
			0: return ctok_pkg::CH_SPACE;
			1: return ctok_pkg::CH_LF;
			2: return 8'h09;
			3: return ctok_pkg::CH_CR;
			4: return 8'($urandom_range(1, 32));
			default: return 8'($urandom_range(128, 255));
		endcase
	endfunction

	function automatic logic [7:0] rand_op_start();
		case ($urandom_range(3))
			0: return ctok_pkg::CH_PLUS;
			1: return ctok_pkg::CH_EQ;
			2: return ctok_pkg::CH_AMP;
			default: return ctok_pkg::CH_SLASH;
		endcase
	endfunction

	// Send one token, comment or blank run with random content, some left unterminated, or noise.
	task automatic send_random_token();
		string      kw;
		int         n;
		logic [7:0] b;
		case ($urandom_range(11))
			0: send_text(keyword_of($urandom_range(6)));
			1: begin
				n = ($urandom_range(9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
				send_byte(rand_letter(), 1'b0);
				repeat (n - 1) send_byte(rand_word_char(), 1'b0);
			end
			2: begin
				// Near misses of a keyword: one byte short or one byte long.
				kw = keyword_of($urandom_range(6));
				if ($urandom_range(1)) begin
					send_text(kw.substr(0, kw.len() - 2));
				end else begin
					send_text(kw);
					send_byte(rand_word_char(), 1'b0);
				end
			end
			3: begin
				send_byte(rand_numeral(), 1'b0);
				repeat ($urandom_range(5)) begin
					send_byte(($urandom_range(3) == 0) ? ctok_pkg::CH_DOT : rand_numeral(),
						1'b0);
				end
			end
			4: begin
				send_byte(ctok_pkg::CH_QUOTE, 1'b0);
				repeat ($urandom_range(8)) begin
					do begin
						b = 8'($urandom_range(1, 255));
					end while (b == ctok_pkg::CH_QUOTE || b == ctok_pkg::CH_CR ||
						b == ctok_pkg::CH_LF);
					send_byte(b, 1'b0);
				end
				case ($urandom_range(9))
					7: send_byte(ctok_pkg::CH_LF, 1'b0);
					8: send_byte(ctok_pkg::CH_CR, 1'b0);
					9: send_byte(ctok_pkg::CH_NUL, 1'b0);
					default: send_byte(ctok_pkg::CH_QUOTE, 1'b0);
				endcase
			end
			5: begin
				b = rand_op_start();
				if (b == ctok_pkg::CH_SLASH) begin
					b = ctok_pkg::CH_PLUS;
				end
				send_byte(b, 1'b0);
				send_byte(b, 1'b0);
			end
			6: send_byte(rand_op_start(), 1'b0);
			7: send_byte(8'($urandom_range(33, 127)), 1'b0);
			8: begin
				send_text("//");
				repeat ($urandom_range(6)) begin
					do begin
						b = 8'($urandom_range(1, 255));
					end while (b == ctok_pkg::CH_CR || b == ctok_pkg::CH_LF);
					send_byte(b, 1'b0);
				end
				send_byte(($urandom_range(3) == 0) ? ctok_pkg::CH_CR : ctok_pkg::CH_LF, 1'b0);
			end
			9: begin
				send_text("/*");
				repeat ($urandom_range(8)) begin
					case ($urandom_range(7))
						0, 1: send_byte(ctok_pkg::CH_STAR, 1'b0);
						2: send_byte(ctok_pkg::CH_LF, 1'b0);
						3: send_byte(ctok_pkg::CH_SLASH, 1'b0);
						default: send_byte(8'($urandom_range(1, 255)), 1'b0);
					endcase
				end
				if ($urandom_range(9) == 0) begin
					send_byte(ctok_pkg::CH_NUL, 1'b0);
				end else begin
					send_text("*/");
				end
			end
			10: begin
				repeat ($urandom_range(1, 3)) send_byte(rand_blank(), 1'b0);
			end
			default: send_byte(8'($urandom_range(255)), $urandom_range(39) == 0);
		endcase
		if ($urandom_range(1)) begin
			send_byte(rand_blank(), 1'b0);
		end
	endtask

	// Field extremes, a keyword and every other token kind, comments, both error kinds and the end byte.
	task automatic test_directed();
		send_byte(8'hFF, 1'b1);
		send_text("int==1.5&&\"a");
		send_byte(8'hFF, 1'b0);
		send_byte(ctok_pkg::CH_LF, 1'b0);
		send_text("+x++=/;");
		send_byte(8'h7F, 1'b0);
		send_byte(8'h80, 1'b0);
		send_text("//c");
		send_byte(ctok_pkg::CH_LF, 1'b0);
		send_text("/*");
		send_byte(ctok_pkg::CH_LF, 1'b0);
		send_text("*/a");
		send_byte(ctok_pkg::CH_NUL, 1'b0);
		send_text("/*");
		send_byte(ctok_pkg::CH_NUL, 1'b0);
		send_byte(ctok_pkg::CH_QUOTE, 1'b0);
		send_byte(ctok_pkg::CH_NUL, 1'b0);
	endtask

	// A restart drops the token, string or comment in progress and resets the line.
	task automatic test_restart();
		send_text("ab");
		send_byte("1", 1'b1);
		send_byte(ctok_pkg::CH_QUOTE, 1'b0);
		send_byte("q", 1'b0);
		send_byte(ctok_pkg::CH_SLASH, 1'b1);
		send_text("/*");
		send_byte(ctok_pkg::CH_LF, 1'b0);
		send_byte("x", 1'b1);
		send_byte(ctok_pkg::CH_NUL, 1'b0);
	endtask

	// Random source text of about n bytes, closed by the end byte.
	task automatic test_token_stream(input int n, input int idle_pct, input int stall_pct);
		int first;
		src_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		first = bytes_sent;
		while (bytes_sent - first < n) begin
			send_random_token();
		end
		send_byte(ctok_pkg::CH_NUL, 1'b0);
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		wait_drained();
		test_restart();
		wait_drained();
		test_token_stream(275, 0, 0);
		wait_drained();
		test_token_stream(275, 70, 0);
		wait_drained();
		test_token_stream(275, 0, 70);
		wait_drained();
		test_token_stream(275, 14, 14);
		wait_drained();
		if (errors == 0 && expected_tokens.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Guard against a hang.
	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

@@ c_like_source_tokenizer.f @@
src/ctok_pkg.sv
src/ctok_lexer.sv
src/ctok_rqueue.sv
src/c_like_source_tokenizer.sv
dv/tb.sv
